// ----- hw/rtl/fdl_pkg.sv -----
// fdl_pkg: shared constants, register codes and fixed-point helpers for the
// feedback delay line; depends on nothing
package fdl_pkg;

    localparam int DELAY_DEPTH_DEF = 65536;
    localparam int CHANNELS_DEF    = 2;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int RATE_W     = 18;
    localparam int MS_W       = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // delay = floor(rate * ms / 1000) through a reciprocal and one correction
    localparam int      PROD_W     = RATE_W + MS_W;
    localparam int      RECIP_W    = 30;
    localparam int      RECIP_SH   = 39;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 30'd549755813;
    localparam int      Q_W        = 20;
    localparam int      MS_PER_SEC = 1000;
    localparam int      DLY_LAT    = 3;

    localparam logic signed [17:0] GAIN_POINT_EIGHT = 18'sd52429;
    localparam logic signed [17:0] GAIN_POINT_TWO   = 18'sd13107;

    localparam logic [RATE_W-1:0] RATE_RST = 18'd48000;
    localparam logic [MS_W-1:0]   MS_RST   = 11'd500;
    localparam logic [GAIN_W-1:0] FB_RST   = 16'd32768;
    localparam logic [GAIN_W-1:0] MIX_RST  = 16'd19661;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE   = 2'd0,
        REG_DELAY_MS      = 2'd1,
        REG_FEEDBACK_GAIN = 2'd2,
        REG_MIX_LEVEL     = 2'd3
    } cfg_reg_t;

    // round half up, divide by 2^16, saturate to q1.15
    function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [35:0] acc);
        logic signed [36:0] p;
        logic signed [20:0] q;
        logic signed [SAMPLE_W-1:0] r;
        p = {acc[35], acc} + 37'sd32768;
        q = p[36:16];
        if (q > 21'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (q < -21'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = q[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [16:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 17'sd32767)
        begin
            r = 16'sh7FFF;
        end
        else if (v < -17'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/feedback_delay_line.sv -----
// feedback_delay_line: per-channel echo with feedback and dry/wet mix
// depends on fdl_pkg; holds the delay store memory and a small output queue
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------
//  input     | in        | in_valid / in_stall | channel, in_sample
//  output    | out       | out_valid/out_stall | out_sample, delay_capped
//  config    | in        | cfg_we              | cfg_index, cfg_data
//
// one sample per cycle while in_stall is low; a result passes stage 1, stage 2 and the output queue
// reset clears the store one entry a cycle, with in_stall high until the clearing pass ends
// a write of sample_rate or delay_ms stalls the input while the delay is recomputed
// the input stalls when a sample reads the entry written by the sample just before it
// input stalls when the 4-entry output queue plus in-flight requests would overflow
module feedback_delay_line #(
    parameter int DELAY_DEPTH = fdl_pkg::DELAY_DEPTH_DEF,
    parameter int CHANNELS    = fdl_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fdl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fdl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 channel,
    input  logic signed [fdl_pkg::SAMPLE_W-1:0]  in_sample,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [fdl_pkg::SAMPLE_W-1:0]  out_sample,
    output logic                                 delay_capped
);
    import fdl_pkg::*;

    localparam int POS_W     = $clog2(DELAY_DEPTH);
    localparam int MEM_DEPTH = 2 * DELAY_DEPTH;
    localparam int ADDR_W    = POS_W + 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(DELAY_DEPTH - 1);
    localparam logic [Q_W:0]      DLY_MAX   = (Q_W + 1)'(DELAY_DEPTH - 1);

    // configuration registers
    logic [RATE_W-1:0] sample_rate_reg;
    logic [MS_W-1:0]   delay_ms_reg;
    logic [GAIN_W-1:0] feedback_gain_reg;
    logic [GAIN_W-1:0] mix_level_reg;
    logic [1:0]        cfg_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg   <= RATE_RST;
            delay_ms_reg      <= MS_RST;
            feedback_gain_reg <= FB_RST;
            mix_level_reg     <= MIX_RST;
            cfg_busy_reg      <= '0;
        end
        else
        begin
            if (cfg_busy_reg != 2'd0)
            begin
                cfg_busy_reg <= cfg_busy_reg - 2'd1;
            end
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_SAMPLE_RATE:
                    begin
                        sample_rate_reg <= cfg_data[RATE_W-1:0];
                        cfg_busy_reg    <= 2'(DLY_LAT);
                    end
                    REG_DELAY_MS:
                    begin
                        delay_ms_reg <= cfg_data[MS_W-1:0];
                        cfg_busy_reg <= 2'(DLY_LAT);
                    end
                    REG_FEEDBACK_GAIN:
                    begin
                        feedback_gain_reg <= cfg_data[GAIN_W-1:0];
                    end
                    REG_MIX_LEVEL:
                    begin
                        mix_level_reg <= cfg_data[GAIN_W-1:0];
                    end
                    default:
                    begin
                        cfg_busy_reg <= cfg_busy_reg;
                    end
                endcase
            end
        end
    end

    // delay length: product, reciprocal multiply, correction and cap
    logic [PROD_W-1:0]           dp_prod_reg;
    logic [PROD_W-1:0]           dp_prod2_reg;
    logic [PROD_W+RECIP_W-1:0]   dp_recip_reg;
    logic [Q_W-1:0]              dp_q0;
    logic [PROD_W:0]             dp_rem;
    logic [Q_W:0]                dp_q;
    logic [POS_W-1:0]            delay_reg;
    logic                        capped_reg;

    always_comb
    begin
        dp_q0  = dp_recip_reg[RECIP_SH +: Q_W];
        dp_rem = {1'b0, dp_prod2_reg}
                 - ((PROD_W + 1)'(dp_q0) * (PROD_W + 1)'(MS_PER_SEC));
        dp_q   = {1'b0, dp_q0} + ((dp_rem >= (PROD_W + 1)'(MS_PER_SEC)) ? 21'd1 : 21'd0);
    end

    always_ff @(posedge clk)
    begin
        dp_prod_reg  <= sample_rate_reg * delay_ms_reg;
        dp_prod2_reg <= dp_prod_reg;
        dp_recip_reg <= dp_prod_reg * RECIP_1000;
        if (dp_q > DLY_MAX)
        begin
            delay_reg  <= LAST_POS;
            capped_reg <= 1'b1;
        end
        else
        begin
            delay_reg  <= POS_W'(dp_q);
            capped_reg <= 1'b0;
        end
    end

    // clearing pass after reset
    logic              clear_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg      <= 1'b1;
            clear_addr_reg <= '0;
        end
        else if (clear_reg)
        begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == LAST_ADDR)
            begin
                clear_reg <= 1'b0;
            end
        end
    end

    // request side: read address, hazard check, position
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [POS_W-1:0]  rd_pos;
    logic [ADDR_W-1:0] rd_addr;
    logic              in_range;
    logic              last_chan;
    logic              dly_zero;
    logic              hazard;
    logic              accept;
    logic [FIFO_CNT_W-1:0] fifo_count_reg;
    logic              full_soon;

    logic                       s1_valid_reg;
    logic                       s1_in_range_reg;
    logic                       s1_dzero_reg;
    logic                       s1_capped_reg;
    logic                       s1_ch_reg;
    logic [POS_W-1:0]           s1_pos_reg;
    logic [ADDR_W-1:0]          s1_rd_addr_reg;
    logic signed [SAMPLE_W-1:0] s1_dry_reg;

    logic                       s2_valid_reg;
    logic                       s2_wr_en_reg;
    logic                       s2_capped_reg;
    logic [ADDR_W-1:0]          s2_wr_addr_reg;
    logic signed [SAMPLE_W-1:0] s2_dry_reg;
    logic signed [32:0]         s2_fb_prod_reg;
    logic signed [33:0]         s2_dry_prod_reg;
    logic signed [33:0]         s2_wet_prod_reg;

    always_comb
    begin
        in_range  = int'(channel) < CHANNELS;
        last_chan = int'(channel) == (CHANNELS - 1);
        dly_zero  = delay_reg == '0;
        if (pos_reg >= delay_reg)
        begin
            rd_pos = pos_reg - delay_reg;
        end
        else
        begin
            rd_pos = POS_W'({1'b0, pos_reg} + (POS_W + 1)'(DELAY_DEPTH) - {1'b0, delay_reg});
        end
        rd_addr   = {rd_pos, channel};
        pos_next  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
        hazard    = s1_valid_reg && s1_in_range_reg && in_range && !dly_zero
                    && (rd_addr == {s1_pos_reg, s1_ch_reg});
        full_soon = (fifo_count_reg + FIFO_CNT_W'(s1_valid_reg) + FIFO_CNT_W'(s2_valid_reg))
                    >= FIFO_CNT_W'(FIFO_DEPTH);
        in_stall  = clear_reg || (cfg_busy_reg != 2'd0) || full_soon || hazard;
        accept    = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (accept && in_range && last_chan)
        begin
            pos_reg <= pos_next;
        end
    end

    // delay store
    logic [SAMPLE_W-1:0]        store_mem [MEM_DEPTH];
    logic [SAMPLE_W-1:0]        rd_data_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [SAMPLE_W-1:0]        mem_wdata;
    logic signed [SAMPLE_W-1:0] wr_sample;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // last item write, forwarded to a read issued at the same edge
    logic                       fwd_valid_reg;
    logic [ADDR_W-1:0]          fwd_addr_reg;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;

    // stage 1: wet select and products
    logic signed [SAMPLE_W-1:0] wet;
    logic signed [SAMPLE_W-1:0] wet_mem;
    logic signed [17:0]         dry_gain;
    logic signed [17:0]         wet_gain;

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_rd_addr_reg))
        begin
            wet_mem = fwd_data_reg;
        end
        else
        begin
            wet_mem = $signed(rd_data_reg);
        end
        if (!s1_in_range_reg)
        begin
            wet = '0;
        end
        else if (s1_dzero_reg)
        begin
            wet = s1_dry_reg;
        end
        else
        begin
            wet = wet_mem;
        end
        dry_gain = GAIN_POINT_EIGHT - $signed({2'b00, mix_level_reg});
        wet_gain = GAIN_POINT_TWO + $signed({2'b00, mix_level_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_in_range_reg <= in_range;
            s1_dzero_reg    <= dly_zero;
            s1_capped_reg   <= capped_reg;
            s1_ch_reg       <= channel;
            s1_pos_reg      <= pos_reg;
            s1_rd_addr_reg  <= rd_addr;
            s1_dry_reg      <= in_sample;
        end
        s2_wr_en_reg    <= s1_in_range_reg;
        s2_capped_reg   <= s1_capped_reg;
        s2_wr_addr_reg  <= {s1_pos_reg, s1_ch_reg};
        s2_dry_reg      <= s1_dry_reg;
        s2_fb_prod_reg  <= wet * $signed({1'b0, feedback_gain_reg});
        s2_dry_prod_reg <= s1_dry_reg * dry_gain;
        s2_wet_prod_reg <= wet * wet_gain;
    end

    // stage 2: store update and mixed result
    logic signed [SAMPLE_W-1:0] fb_sample;
    logic signed [SAMPLE_W-1:0] mix_sample;
    logic                       item_write;

    always_comb
    begin
        fb_sample  = round_sat({{3{s2_fb_prod_reg[32]}}, s2_fb_prod_reg});
        wr_sample  = sat16({s2_dry_reg[15], s2_dry_reg} + {fb_sample[15], fb_sample});
        mix_sample = round_sat({{2{s2_dry_prod_reg[33]}}, s2_dry_prod_reg}
                               + {{2{s2_wet_prod_reg[33]}}, s2_wet_prod_reg});
        item_write = s2_valid_reg && s2_wr_en_reg;
        mem_we     = clear_reg || item_write;
        mem_waddr  = clear_reg ? clear_addr_reg : s2_wr_addr_reg;
        mem_wdata  = clear_reg ? '0 : wr_sample;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (item_write)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_write)
        begin
            fwd_addr_reg <= s2_wr_addr_reg;
            fwd_data_reg <= wr_sample;
        end
    end

    // output queue
    logic signed [SAMPLE_W-1:0] fifo_sample_reg [FIFO_DEPTH];
    logic                       fifo_capped_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]      fifo_wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]      fifo_rd_ptr_reg;
    logic                       pop;

    assign out_valid    = fifo_count_reg != '0;
    assign out_sample   = fifo_sample_reg[fifo_rd_ptr_reg];
    assign delay_capped = fifo_capped_reg[fifo_rd_ptr_reg];
    assign pop          = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_count_reg  <= '0;
            fifo_wr_ptr_reg <= '0;
            fifo_rd_ptr_reg <= '0;
        end
        else
        begin
            if (s2_valid_reg)
            begin
                fifo_wr_ptr_reg <= fifo_wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                fifo_rd_ptr_reg <= fifo_rd_ptr_reg + 1'b1;
            end
            fifo_count_reg <= fifo_count_reg + FIFO_CNT_W'(s2_valid_reg) - FIFO_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            fifo_sample_reg[fifo_wr_ptr_reg] <= mix_sample;
            fifo_capped_reg[fifo_wr_ptr_reg] <= s2_capped_reg;
        end
    end

    // checks
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("output queue overflow");

    a_no_clear_write: assert property (@(posedge clk) disable iff (!rst_n)
        item_write |-> !clear_reg)
        else $error("item write during clearing pass");

    a_read_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_in_range_reg && !s1_dzero_reg && item_write)
        |-> (s1_rd_addr_reg != s2_wr_addr_reg))
        else $error("read overtook a pending write to the same entry");

    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(pos_reg))
        else $error("write position moved without a request");

endmodule
